>>> rtl/sbdv_pkg.sv
// Shared types and constants for the saved-game decrypt and verify block.
// No dependencies.
`default_nettype none
package sbdv_pkg;
    localparam int MAX_ITEM_CAPACITY  = 1024;
    localparam int MAX_TIMER_CAPACITY = 4096;
    localparam int CHAR_SECTION_WORDS = 1664;

    localparam logic [2:0] SEC_HEADER = 3'd0;
    localparam logic [2:0] SEC_B2     = 3'd1;
    localparam logic [2:0] SEC_B3     = 3'd2;
    localparam logic [2:0] SEC_ITEMS  = 3'd3;
    localparam logic [2:0] SEC_CHARS  = 3'd4;
    localparam logic [2:0] SEC_TIMERS = 3'd5;
    localparam logic [2:0] SEC_QUEUE  = 3'd6;
    localparam logic [2:0] SEC_TRAIL  = 3'd7;

    localparam logic [3:0] ST_OK     = 4'd0;
    localparam logic [3:0] ST_TRUNC  = 4'd1;
    localparam logic [3:0] ST_B2     = 4'd2;
    localparam logic [3:0] ST_B3     = 4'd3;
    localparam logic [3:0] ST_COUNTS = 4'd4;
    localparam logic [3:0] ST_ITEMS  = 4'd5;
    localparam logic [3:0] ST_CHARS  = 4'd6;
    localparam logic [3:0] ST_TIMERS = 4'd7;
    localparam logic [3:0] ST_QUEUE  = 4'd8;

    localparam logic CFG_ITEM_LIMIT  = 1'b0;
    localparam logic CFG_TIMER_LIMIT = 1'b1;

    typedef struct packed {
        logic [15:0] word;
        logic        last;
        logic        half;
    } t_item;

    typedef struct packed {
        logic [2:0]  section_tag;
        logic [14:0] word_index;
        logic [15:0] plain_word;
        logic        final_flag;
        logic [3:0]  status_code;
    } t_result;
endpackage
`default_nettype wire

>>> rtl/sbdv_queue.sv
// Front end: accepts file words, qualifies the half-word flag, two-entry queue.
// Depends on sbdv_pkg.
`default_nettype none
module sbdv_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic [15:0]     i_file_word,
    input  wire logic            i_is_last,
    input  wire logic            i_half_word,
    output logic                 o_q_valid,
    input  wire logic            i_q_pop,
    output sbdv_pkg::t_item      o_q_item
);
    import sbdv_pkg::*;

    t_item      r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic       push, pop;
    t_item      item_in;

    assign o_ready   = (r_count != 2'd2);
    assign o_q_valid = (r_count != 2'd0);
    assign push      = i_valid && o_ready;
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_item  = r_mem[r_rd_ptr];

    always_comb begin
        item_in.word = i_file_word;
        item_in.last = i_is_last;
        // half word only counts on the last word
        item_in.half = i_is_last && i_half_word;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= item_in;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) r_wr_ptr <= ~r_wr_ptr;
            if (pop)  r_rd_ptr <= ~r_rd_ptr;
            r_count <= r_count + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

>>> rtl/sbdv_engine.sv
// Back end: per-word decrypt, checksums, section sequencing, output register.
// Depends on sbdv_pkg.
`default_nettype none
module sbdv_engine (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic            i_cfg_index,
    input  wire logic [12:0]     i_cfg_data,
    input  wire logic            i_q_valid,
    output logic                 o_q_pop,
    input  wire sbdv_pkg::t_item i_q_item,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output sbdv_pkg::t_result    o_result
);
    import sbdv_pkg::*;

    logic [10:0] r_ilim;
    logic [12:0] r_tlim;

    logic [15:0] r_hsum, n_hsum;
    logic [15:0] r_b2key, n_b2key;
    logic [15:0] r_b2sum, n_b2sum;
    logic [15:0] r_keys [5];
    logic [15:0] r_exps [5];
    logic [15:0] r_icount, r_icap, r_tcount, r_tcap;
    logic [15:0] r_key, n_key;
    logic [15:0] r_chk, n_chk;
    logic [14:0] r_step, n_step;
    logic [2:0]  r_sec, n_sec;
    logic [14:0] r_pos, n_pos;
    logic [6:0]  r_flags, n_flags;   // b2, b3, counts, items, chars, timers, queue

    logic        r_out_valid;
    t_result     r_out, n_out;

    logic        take;
    logic [15:0] w, plain, chk_sum;
    logic [2:0]  s;
    logic        completed, counts_ok, trunc;
    logic [10:0] il;
    logic [12:0] tl;
    logic [3:0]  status;

    assign o_q_pop  = i_q_valid && (!r_out_valid || i_ready);
    assign take     = o_q_pop;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    assign w = i_q_item.word;
    assign s = r_sec;
    assign il = (r_ilim > 11'(MAX_ITEM_CAPACITY)) ? 11'(MAX_ITEM_CAPACITY) : r_ilim;
    assign tl = (r_tlim > 13'(MAX_TIMER_CAPACITY)) ? 13'(MAX_TIMER_CAPACITY) : r_tlim;
    assign counts_ok = !(r_icap > {5'd0, il}) && !(r_tcap > {3'd0, tl})
                       && !(r_icount > r_icap) && !(r_tcount > r_tcap);

    always_comb begin
        n_hsum = r_hsum; n_b2key = r_b2key; n_b2sum = r_b2sum;
        n_key = r_key; n_chk = r_chk; n_step = r_step;
        n_sec = r_sec; n_pos = r_pos; n_flags = r_flags;
        completed = 1'b0;
        plain = (s != SEC_HEADER && s != SEC_TRAIL) ? (w ^ r_key) : w;
        chk_sum = r_chk + w + plain;

        if (s == SEC_HEADER) begin
            case (r_pos[1:0])
                2'd0:    n_hsum = r_hsum + w;
                2'd2:    n_hsum = r_hsum - w;
                default: n_hsum = r_hsum ^ w;
            endcase
            if (r_pos == 15'd29) n_b2key = w;
        end else if (s != SEC_TRAIL) begin
            n_key = r_key + {1'b0, r_step};
            n_chk = chk_sum;
            if (s == SEC_B2) n_b2sum = r_b2sum + plain;
        end

        if (s != SEC_TRAIL) begin
            n_pos  = r_pos + 15'd1;
            n_step = r_step - 15'd1;
            completed = (r_step == 15'd1);
            if (completed) begin
                n_pos = 15'd0;
                case (s)
                    SEC_HEADER: begin
                        n_sec = SEC_B2; n_key = r_b2key; n_chk = r_b2key; n_step = 15'd128;
                    end
                    SEC_B2: begin
                        if (n_b2sum != r_hsum) n_flags[0] = 1'b1;
                        n_sec = SEC_B3; n_key = r_keys[0]; n_chk = r_keys[0]; n_step = 15'd64;
                    end
                    SEC_B3: begin
                        if (chk_sum != r_exps[0]) n_flags[1] = 1'b1;
                        if (!counts_ok) begin
                            n_flags[2] = 1'b1; n_sec = SEC_TRAIL; n_step = 15'd0;
                        end else if (r_icap == 16'd0) begin
                            // empty item table: checked against its key at once
                            if (r_keys[1] != r_exps[1]) n_flags[3] = 1'b1;
                            n_sec = SEC_CHARS; n_key = r_keys[2]; n_chk = r_keys[2];
                            n_step = 15'(CHAR_SECTION_WORDS);
                        end else begin
                            n_sec = SEC_ITEMS; n_key = r_keys[1]; n_chk = r_keys[1];
                            n_step = {1'b0, r_icap[10:0], 3'd0};
                        end
                    end
                    SEC_ITEMS: begin
                        if (chk_sum != r_exps[1]) n_flags[3] = 1'b1;
                        n_sec = SEC_CHARS; n_key = r_keys[2]; n_chk = r_keys[2];
                        n_step = 15'(CHAR_SECTION_WORDS);
                    end
                    SEC_CHARS: begin
                        if (chk_sum != r_exps[2]) n_flags[4] = 1'b1;
                        if (r_tcap == 16'd0) begin
                            // timer and queue sections both empty
                            if (r_keys[3] != r_exps[3]) n_flags[5] = 1'b1;
                            if (r_keys[4] != r_exps[4]) n_flags[6] = 1'b1;
                            n_sec = SEC_TRAIL; n_step = 15'd0;
                        end else begin
                            n_sec = SEC_TIMERS; n_key = r_keys[3]; n_chk = r_keys[3];
                            n_step = {2'd0, r_tcap[12:0]} * 15'd5;
                        end
                    end
                    SEC_TIMERS: begin
                        if (chk_sum != r_exps[3]) n_flags[5] = 1'b1;
                        n_sec = SEC_QUEUE; n_key = r_keys[4]; n_chk = r_keys[4];
                        n_step = {2'd0, r_tcap[12:0]};
                    end
                    SEC_QUEUE: begin
                        if (chk_sum != r_exps[4]) n_flags[6] = 1'b1;
                        n_sec = SEC_TRAIL; n_step = 15'd0;
                    end
                    default: n_sec = SEC_TRAIL;
                endcase
            end
        end else if (r_pos != 15'h7FFF) begin
            n_pos = r_pos + 15'd1;
        end

        trunc = 1'b0;
        if (s == SEC_B3 && n_sec != SEC_TRAIL) trunc = 1'b1;
        if (s inside {[SEC_ITEMS:SEC_QUEUE]} && (i_q_item.half || n_sec != SEC_TRAIL))
            trunc = 1'b1;

        status = ST_OK;
        if (i_q_item.last) begin
            if (s <= SEC_B3 && !(s == SEC_B3 && completed && !i_q_item.half)) status = ST_TRUNC;
            else if (n_flags[0]) status = ST_B2;
            else if (n_flags[1]) status = ST_B3;
            else if (n_flags[2]) status = ST_COUNTS;
            else if (trunc)      status = ST_TRUNC;
            else if (n_flags[3]) status = ST_ITEMS;
            else if (n_flags[4]) status = ST_CHARS;
            else if (n_flags[5]) status = ST_TIMERS;
            else if (n_flags[6]) status = ST_QUEUE;
        end

        n_out.section_tag = s;
        n_out.word_index  = r_pos;
        n_out.plain_word  = plain;
        n_out.final_flag  = i_q_item.last;
        n_out.status_code = status;
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= n_out;
            if (s == SEC_B2) begin
                if (r_pos >= 15'd28 && r_pos <= 15'd32) r_keys[3'(r_pos - 15'd28)] <= plain;
                if (r_pos >= 15'd44 && r_pos <= 15'd48) r_exps[3'(r_pos - 15'd44)] <= plain;
            end
            if (s == SEC_B3) begin
                case (r_pos)
                    15'd12:  r_tcount <= plain;
                    15'd14:  r_tcap   <= plain;
                    15'd15:  r_icount <= plain;
                    15'd23:  r_icap   <= plain;
                    default: ;
                endcase
            end
        end
        if (!i_rst_n) begin
            r_ilim <= 11'(MAX_ITEM_CAPACITY);
            r_tlim <= 13'(MAX_TIMER_CAPACITY);
            r_out_valid <= 1'b0;
            r_hsum <= '0; r_b2key <= '0; r_b2sum <= '0; r_key <= '0; r_chk <= '0;
            r_step <= 15'd128; r_sec <= SEC_HEADER; r_pos <= '0; r_flags <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ITEM_LIMIT:  r_ilim <= i_cfg_data[10:0];
                    CFG_TIMER_LIMIT: r_tlim <= i_cfg_data;
                    default: ;
                endcase
            end
            if (take) r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
            if (take) begin
                if (i_q_item.last) begin
                    // end of file: stream state restarts for the next one
                    r_hsum <= '0; r_b2key <= '0; r_b2sum <= '0; r_key <= '0; r_chk <= '0;
                    r_step <= 15'd128; r_sec <= SEC_HEADER; r_pos <= '0; r_flags <= '0;
                end else begin
                    r_hsum <= n_hsum; r_b2key <= n_b2key; r_b2sum <= n_b2sum;
                    r_key <= n_key; r_chk <= n_chk; r_step <= n_step;
                    r_sec <= n_sec; r_pos <= n_pos; r_flags <= n_flags;
                end
            end
        end
    end
endmodule
`default_nettype wire

>>> rtl/save_block_decrypt_verify_core.sv
// Saved-game decrypt and verify block: input queue front end, processing back end.
// Depends on sbdv_pkg, sbdv_queue, sbdv_engine.
//
// Usage: file words stream in on i_valid/o_ready, big-endian, is_last on the
// final word (half_word with it if only the upper byte is real). Every word
// yields one result on o_valid/i_ready: section tag, index, plaintext, final
// flag, and on the final word the first error found (0 when clean).
// Throughput is one word per cycle while i_ready is held high; the back end
// updates the section state once per word, so words follow each other without gaps.
// A transferred word is written into the queue, then taken into the output
// register, which presents its result. When the receiver stalls, the output
// register holds and the two-entry queue absorbs words before o_ready drops.
// Reset (synchronous, active low) empties the queue, clears stream state and
// sets the limit registers to 1024 and 4096. After each final word the stream
// state restarts for the next file; limits are kept. Limit writes go through
// i_cfg_we/i_cfg_index/i_cfg_data; the user must make them only while the
// block is idle; the block itself does not enforce this.
`default_nettype none
module save_block_decrypt_verify_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [12:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [15:0] i_file_word,
    input  wire logic        i_is_last,
    input  wire logic        i_half_word,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_section_tag,
    output logic [14:0]      o_word_index,
    output logic [15:0]      o_plain_word,
    output logic             o_final_flag,
    output logic [3:0]       o_status_code
);
    import sbdv_pkg::*;

    logic    q_valid, q_pop;
    t_item   q_item;
    t_result result;

    sbdv_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_file_word(i_file_word), .i_is_last(i_is_last), .i_half_word(i_half_word),
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_item(q_item)
    );

    sbdv_engine u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_q_valid(q_valid), .o_q_pop(q_pop), .i_q_item(q_item),
        .o_valid(o_valid), .i_ready(i_ready), .o_result(result)
    );

    assign o_section_tag = result.section_tag;
    assign o_word_index  = result.word_index;
    assign o_plain_word  = result.plain_word;
    assign o_final_flag  = result.final_flag;
    assign o_status_code = result.status_code;

`ifndef SYNTHESIS
    a_status_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status_code != ST_OK) |-> o_final_flag)
        else $error("status reported on a non-final word");
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && o_ready))
        else $error("result or full queue right after reset");
    a_header_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_pop && q_item.last) |=> (u_engine.r_sec == SEC_HEADER))
        else $error("stream state not restarted after final word");
`endif
endmodule
`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for save_block_decrypt_verify_core: builds encrypted save files,
// streams them through valid/ready with random gaps and compares every result to a predictor.
// Depends on sbdv_pkg and the core RTL.
`timescale 1ns / 100ps
module testbench;
    import sbdv_pkg::*;

    typedef logic [15:0] t_word_q[$];

    localparam logic [7:0] E_B2 = 8'h01;
    localparam logic [7:0] E_B3 = 8'h02;
    localparam logic [7:0] E_CNT = 8'h04;
    localparam logic [7:0] E_TRUNC = 8'h08;
    localparam int TS_ICOUNT = 0;
    localparam int TS_ICAP = 1;
    localparam int TS_TCOUNT = 2;
    localparam int TS_TCAP = 3;
    localparam int CYCLE_LIMIT = 3000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [12:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [15:0] i_file_word;
    logic        i_is_last;
    logic        i_half_word;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_section_tag;
    logic [14:0] o_word_index;
    logic [15:0] o_plain_word;
    logic        o_final_flag;
    logic [3:0]  o_status_code;

    save_block_decrypt_verify_core dut (.*);

    t_item   pending_words[$];
    t_result expected_results[$];
    int      n_errors = 0;
    int      n_results = 0;
    int      cycles = 0;
    bit      tx_idle = 0;
    bit      rx_idle = 0;

    // ---------------- predictor state ----------------
    logic [15:0] p_hsum, p_b2key, p_b2sum, p_rkey, p_rchk;
    logic [15:0] p_keys[5];
    logic [15:0] p_sums[5];
    logic [15:0] p_tab[4];
    logic [7:0]  p_err;
    logic [2:0]  p_sec;
    int          p_step, p_pos;
    int          lim_item, lim_timer;

    function void stream_clear();
        p_hsum = 0; p_b2key = 0; p_b2sum = 0; p_rkey = 0; p_rchk = 0;
        for (int i = 0; i < 5; i++) begin
            p_keys[i] = 0;
            p_sums[i] = 0;
        end
        for (int i = 0; i < 4; i++) p_tab[i] = 0;
        p_err = 0; p_sec = SEC_HEADER; p_step = 128; p_pos = 0;
    endfunction

    function int section_len(int s);
        case (s)
            0, 1: return 128;
            2: return 64;
            3: return int'(p_tab[TS_ICAP]) * 8;
            4: return CHAR_SECTION_WORDS;
            5: return int'(p_tab[TS_TCAP]) * 5;
            6: return int'(p_tab[TS_TCAP]);
            default: return 0;
        endcase
    endfunction

    function void section_verify(int s);
        if (s >= 3 && s <= 6 && p_rchk != p_sums[s - 2])
            p_err = p_err | (8'h10 << (s - 3));
    endfunction

    function void section_enter(int s0);
        int s;
        bit done;
        s = s0;
        done = 0;
        while (!done) begin
            p_sec = 3'(s);
            p_pos = 0;
            if (s >= 7) begin
                p_step = 0;
                done = 1;
            end else begin
                p_rkey = (s == 1) ? p_b2key : p_keys[s - 2];
                p_rchk = p_rkey;
                p_step = section_len(s);
                if (p_step != 0) done = 1;
                else begin
                    section_verify(s);
                    s++;
                end
            end
        end
    endfunction

    function bit capacities_ok();
        int il, tl;
        il = lim_item < MAX_ITEM_CAPACITY ? lim_item : MAX_ITEM_CAPACITY;
        tl = lim_timer < MAX_TIMER_CAPACITY ? lim_timer : MAX_TIMER_CAPACITY;
        if (int'(p_tab[TS_ICAP]) > il || int'(p_tab[TS_TCAP]) > tl) return 0;
        if (p_tab[TS_ICOUNT] > p_tab[TS_ICAP]) return 0;
        if (p_tab[TS_TCOUNT] > p_tab[TS_TCAP]) return 0;
        return 1;
    endfunction

    function void section_close(int s);
        if (s == 0) section_enter(1);
        else if (s == 1) begin
            if (p_b2sum != p_hsum) p_err |= E_B2;
            section_enter(2);
        end else if (s == 2) begin
            if (p_rchk != p_sums[0]) p_err |= E_B3;
            if (!capacities_ok()) begin
                p_err |= E_CNT;
                section_enter(7);
            end else section_enter(3);
        end else begin
            section_verify(s);
            section_enter(s + 1);
        end
    endfunction

    function t_result decrypt_word(logic [15:0] w, logic last, logic half_in);
        t_result r;
        int s, idx;
        logic [15:0] plain;
        logic half;
        bit completed;
        logic [3:0] st;
        half = last & half_in;
        s = p_sec;
        idx = p_pos > 32767 ? 32767 : p_pos;
        plain = w;
        completed = 0;
        st = ST_OK;
        if (s == SEC_HEADER) begin
            case (p_pos & 3)
                0: p_hsum = p_hsum + w;
                2: p_hsum = p_hsum - w;
                default: p_hsum = p_hsum ^ w;
            endcase
            if (p_pos == 29) p_b2key = w;
        end else if (s < SEC_TRAIL) begin
            plain = w ^ p_rkey;
            p_rchk = p_rchk + w + plain;
            p_rkey = p_rkey + 16'(p_step);
            if (s == SEC_B2) begin
                p_b2sum = p_b2sum + plain;
                if (p_pos >= 28 && p_pos <= 32) p_keys[p_pos - 28] = plain;
                if (p_pos >= 44 && p_pos <= 48) p_sums[p_pos - 44] = plain;
            end else if (s == SEC_B3) begin
                if (p_pos == 12) p_tab[TS_TCOUNT] = plain;
                else if (p_pos == 14) p_tab[TS_TCAP] = plain;
                else if (p_pos == 15) p_tab[TS_ICOUNT] = plain;
                else if (p_pos == 23) p_tab[TS_ICAP] = plain;
            end
        end
        if (s < SEC_TRAIL) begin
            p_pos++;
            if (p_step > 0) p_step--;
            if (p_step == 0) begin
                completed = 1;
                section_close(s);
            end
        end else if (p_pos < 32'h7FFFFFFF) p_pos++;
        if (last) begin
            if (s <= 2 && !(s == 2 && completed && !half)) st = ST_TRUNC;
            else begin
                if (s == 2 && p_sec != SEC_TRAIL) p_err |= E_TRUNC;
                if (s >= 3 && s <= 6 && (half || p_sec != SEC_TRAIL)) p_err |= E_TRUNC;
                if (p_err & E_B2) st = ST_B2;
                else if (p_err & E_B3) st = ST_B3;
                else if (p_err & E_CNT) st = ST_COUNTS;
                else if (p_err & E_TRUNC) st = ST_TRUNC;
                else if (p_err & 8'h10) st = ST_ITEMS;
                else if (p_err & 8'h20) st = ST_CHARS;
                else if (p_err & 8'h40) st = ST_TIMERS;
                else if (p_err & 8'h80) st = ST_QUEUE;
            end
        end
        r.section_tag = 3'(s);
        r.word_index = 15'(idx);
        r.plain_word = plain;
        r.final_flag = last;
        r.status_code = st;
        if (last) stream_clear();
        return r;
    endfunction

    // ---------------- file builder ----------------
    function automatic t_word_q random_words(int n);
        t_word_q q;
        for (int i = 0; i < n; i++) q.push_back(16'($urandom));
        return q;
    endfunction

    function automatic t_word_q encrypt(t_word_q pl, logic [15:0] key, output logic [15:0] chk);
        t_word_q c;
        logic [15:0] k;
        int n;
        k = key;
        n = pl.size();
        chk = key;
        for (int j = 0; j < n; j++) begin
            c.push_back(pl[j] ^ k);
            chk = chk + c[j] + pl[j];
            k = k + 16'(n - j);
        end
        return c;
    endfunction

    task automatic queue_file(t_word_q f, bit half_end);
        t_item it;
        for (int j = 0; j < f.size(); j++) begin
            it.word = f[j];
            it.last = (j == f.size() - 1);
            it.half = it.last ? half_end : 1'($urandom);
            pending_words.push_back(it);
        end
    endtask

    // bad: 0 none, 1 block 2 sum, 2..6 check of block 3, items, chars, timers, queue
    task automatic build_file(int icap, int icnt, int tcap, int tcnt, bit body, int bad,
                              int cut, bit half_end, int trail_n);
        t_word_q hdr, b2, sec[5], cip[5], f;
        logic [15:0] k[5];
        logic [15:0] e[5];
        logic [15:0] hs, ps, b2k, dummy;
        int lens[5];
        lens[0] = 64; lens[1] = 8 * icap; lens[2] = CHAR_SECTION_WORDS;
        lens[3] = 5 * tcap; lens[4] = tcap;
        for (int i = 0; i < 5; i++) begin
            k[i] = 16'($urandom);
            sec[i] = random_words(lens[i]);
        end
        sec[0][12] = 16'(tcnt); sec[0][14] = 16'(tcap);
        sec[0][15] = 16'(icnt); sec[0][23] = 16'(icap);
        for (int i = 0; i < 5; i++) cip[i] = encrypt(sec[i], k[i], e[i]);
        if (bad >= 2) e[bad - 2] = e[bad - 2] ^ 16'(1 << $urandom_range(0, 15));
        hdr = random_words(128);
        b2k = hdr[29];
        hs = 0;
        for (int j = 0; j < 128; j++) begin
            case (j & 3)
                0: hs = hs + hdr[j];
                2: hs = hs - hdr[j];
                default: hs = hs ^ hdr[j];
            endcase
        end
        b2 = random_words(128);
        for (int i = 0; i < 5; i++) begin
            b2[28 + i] = k[i];
            b2[44 + i] = e[i];
        end
        ps = 0;
        for (int j = 0; j < 127; j++) ps = ps + b2[j];
        b2[127] = hs - ps;
        if (bad == 1) b2[127] = b2[127] ^ 16'h0001;
        f = {hdr, encrypt(b2, b2k, dummy), cip[0]};
        if (body) f = {f, cip[1], cip[2], cip[3], cip[4]};
        f = {f, random_words(trail_n)};
        if (cut > 0 && cut < f.size()) f = f[0:cut - 1];
        queue_file(f, half_end);
    endtask

    task automatic noise_file(int n);
        queue_file(random_words(n), 1'($urandom));
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || i_valid || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic wait_room();
        while (pending_words.size() > 64) @(negedge i_clk);
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
    endtask

    task automatic write_limit(logic idx, int v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= 13'(v);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_ITEM_LIMIT) lim_item = v & 16'h7FF;
        else lim_timer = v & 16'h1FFF;
        @(negedge i_clk);
    endtask

    task report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, n_results);
        n_errors++;
    endtask

    // ---------------- clock, reset ----------------
    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL save_block_decrypt_verify_core");
            $finish;
        end
    end

    // ---------------- driver ----------------
    int tx_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_gap <= 0;
        end else begin
            if (i_valid && o_ready)
                expected_results.push_back(decrypt_word(i_file_word, i_is_last, i_half_word));
            if (i_valid && !o_ready) begin
                // hold the offered word
            end else if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                i_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
                i_file_word <= pending_words[0].word;
                i_is_last <= pending_words[0].last;
                i_half_word <= pending_words[0].half;
                void'(pending_words.pop_front());
                i_valid <= 1'b1;
                tx_gap <= tx_idle ? $urandom_range(0, 8) : 0;
            end else i_valid <= 1'b0;
        end
    end

    // ---------------- monitor ----------------
    int rx_stall = 0;
    int rx_hold = 0;
    int rx_draw;
    bit rx_xfer;
    t_result want;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_stall <= 0;
            rx_hold <= 0;
        end else begin
            rx_xfer = o_valid && i_ready;
            rx_draw = 0;
            if (rx_xfer) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("extra result", n_results, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_section_tag != want.section_tag)
                        report_mismatch("section_tag", o_section_tag, want.section_tag);
                    if (o_word_index != want.word_index)
                        report_mismatch("word_index", o_word_index, want.word_index);
                    if (o_plain_word != want.plain_word)
                        report_mismatch("plain_word", o_plain_word, want.plain_word);
                    if (o_final_flag != want.final_flag)
                        report_mismatch("final_flag", o_final_flag, want.final_flag);
                    if (o_status_code != want.status_code)
                        report_mismatch("status_code", o_status_code, want.status_code);
                end
                n_results <= n_results + 1;
                rx_draw = rx_idle ? $urandom_range(0, 8) : 0;
            end
            // long back-pressure so the input side fills and stalls
            if (rx_hold > 0) begin
                rx_hold <= rx_hold - 1;
                i_ready <= 1'b0;
            end else if (rx_xfer && (n_results == 400 || n_results == 800)) begin
                rx_hold <= 300;
                i_ready <= 1'b0;
            end else if (rx_xfer && rx_draw > 0) begin
                rx_stall <= rx_draw - 1;
                i_ready <= 1'b0;
            end else if (!rx_xfer && rx_stall > 0) begin
                rx_stall <= rx_stall - 1;
                i_ready <= 1'b0;
            end else i_ready <= 1'b1;
        end
    end

    // ---------------- stimulus ----------------
    int lim_i[2] = '{1024, 0};
    int lim_t[2] = '{4096, 0};
    initial begin
        int il, tl, ic, tc;
        i_rst_n = 0; i_cfg_we = 0; i_cfg_index = 0; i_cfg_data = 0;
        i_valid = 0; i_ready = 0; i_file_word = 0; i_is_last = 0; i_half_word = 0;
        lim_item = 1024; lim_timer = 4096;
        stream_clear();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: one-word files, extremes, half word with and without last
        queue_file({16'hFFFF}, 1'b1);
        queue_file({16'h0000}, 1'b0);
        queue_file({16'h0000, 16'hFFFF, 16'h8001}, 1'b1);
        noise_file(16);
        // block 3 ends on a half word: short file
        build_file(0, 0, 0, 0, 0, 0, 320, 1, 0);
        wait_drained();

        lim_i[1] = ($urandom_range(0, 1) != 0) ? 2047 : $urandom_range(0, 7);
        lim_t[1] = ($urandom_range(0, 1) != 0) ? 8191 : $urandom_range(0, 7);
        for (int ph = 0; ph < 2; ph++) begin
            if (ph > 0) begin
                write_limit(CFG_ITEM_LIMIT, lim_i[ph]);
                write_limit(CFG_TIMER_LIMIT, lim_t[ph]);
            end
            il = lim_item < MAX_ITEM_CAPACITY ? lim_item : MAX_ITEM_CAPACITY;
            tl = lim_timer < MAX_TIMER_CAPACITY ? lim_timer : MAX_TIMER_CAPACITY;
            il = il > 3 ? 3 : il;
            tl = tl > 4 ? 4 : tl;
            wait_room();
            ic = $urandom_range(0, il);
            tc = $urandom_range(0, tl);
            // capacities are checked at the end of block 3; later words show the next section
            case ($urandom_range(0, 3))
                0: build_file(ic, $urandom_range(0, ic), tc, $urandom_range(0, tc), 0,
                              $urandom_range(0, 2), 0, 0, $urandom_range(1, 12));
                1: build_file(ic, ic + 1, tc, tc, 0, $urandom_range(0, 2), 0, 0,
                              $urandom_range(1, 12));
                2: build_file(ic, ic, tc, tc + 1, 0, 0, 0, 1'($urandom),
                              $urandom_range(0, 12));
                default: build_file(il < 3 ? il + 1 : ic, ic + (il < 3 ? 0 : 1),
                                    tl < 4 ? tl + 1 : tc, tc, 0, 0, 0, 0, 5);
            endcase
            for (int z = 0; z < 2; z++) begin
                wait_room();
                noise_file($urandom_range(1, 20));
            end
            // sender waits here until every result is in
            wait_drained();
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (n_errors == 0) $display("PASS save_block_decrypt_verify_core");
        else $display("FAIL save_block_decrypt_verify_core");
        $finish;
    end
endmodule
